// ----- hw/rtl/gdpp_pkg.sv -----
// ----------------------------------------------------------------------------
// gdpp_pkg
// shared types and constants of the gamma, dither and pixel pack block
// ----------------------------------------------------------------------------
`default_nettype none

package gdpp_pkg;

   // one linear rgba pixel, signed fixed point
   typedef struct packed {
      logic signed [15:0] red_linear;
      logic signed [15:0] green_linear;
      logic signed [15:0] blue_linear;
      logic signed [15:0] alpha_linear;
   } pixel_in_type;

   // one packed result beat
   typedef struct packed {
      logic [31:0] packed_pixel;
   } pixel_out_type;

   localparam int RAW_W  = 16;
   localparam int BYTE_W = 8;

   // configuration register indexes
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_DITHER_ENABLE = 1'b0;
   localparam csr_index_type CSR_BYTE_ORDER    = 1'b1;

   // byte order codes
   localparam logic ORDER_ABGR = 1'b0;
   localparam logic ORDER_RGBA = 1'b1;

   // lcg step
   localparam logic [31:0] LCG_MUL = 32'd214013;
   localparam logic [31:0] LCG_ADD = 32'd2531011;

   localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE,
      CH_ALPHA
   } chan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_STEP,
      ST_ROUND,
      ST_ALPHA,
      ST_PACK
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/gdpp_stream_if.sv -----
// ----------------------------------------------------------------------------
// gdpp_stream_if
// valid/ready channel carrying one payload per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface gdpp_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ----- hw/rtl/gamma_dither_pixel_pack.sv -----
// ----------------------------------------------------------------------------
// gamma_dither_pixel_pack
// linear rgba to gamma-corrected, optionally dithered rgba8888 packer
// ----------------------------------------------------------------------------
// Takes one linear rgba pixel per req beat (signed fixed point with
// INPUT_FRAC_BITS fraction bits) and returns one 32-bit packed pixel per rsp
// beat. Red, green and blue are clamped to [0,1] and looked up in a gamma 1/2.2
// rom holding the corrected value at 0..255 with DITHER_FRAC_BITS fraction bits;
// alpha is clamped and scaled by 255 with no gamma. With dither_enable set, a
// 32-bit lcg advances once per colour channel (red, green, blue) and rounds the
// byte up when its bits 30..16 fall below the channel fraction. byte_order 0
// packs abgr (red in the low byte), 1 packs rgba (red in the high byte). One
// sequencer walks the channels through the single rom port and the single lcg
// unit: for each colour channel a rom read, an lcg step and a round, then
// an alpha step and a pack step that loads the output register; the pack
// step waits while an earlier result there is still unaccepted. The block
// accepts the next pixel only once back in idle. The output register lets a
// new pixel be taken while the previous result waits. Configuration writes are
// taken at any edge with csr_we high and must only be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module gamma_dither_pixel_pack #(
   parameter int INPUT_FRAC_BITS  = 12,
   parameter int DITHER_FRAC_BITS = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   gdpp_stream_if.sink                  req_chan,
   gdpp_stream_if.source                rsp_chan,
   input  wire logic                    csr_we,
   input  wire gdpp_pkg::csr_index_type csr_index,
   input  wire logic                    csr_wdata
);
   import gdpp_pkg::*;

   localparam int CLAMP_W = INPUT_FRAC_BITS + 1;
   localparam int EXT_W   = RAW_W + 1;
   localparam int Y_W     = DITHER_FRAC_BITS + 8;
   localparam int ALPHA_W = CLAMP_W + 8;

   // fsm and control
   state_type state_ff;
   state_type state_in;
   chan_type  chan_ff;
   chan_type  chan_in;

   logic req_ready;
   logic rom_rd_en;
   logic seed_step;
   logic colour_load;
   logic alpha_load;
   logic pack_load;

   // configuration
   logic dither_enable_ff;
   logic byte_order_ff;

   // captured pixel and channel bytes
   pixel_in_type       pix_ff;
   logic [BYTE_W-1:0]  red_ff;
   logic [BYTE_W-1:0]  green_ff;
   logic [BYTE_W-1:0]  blue_ff;
   logic [BYTE_W-1:0]  alpha_ff;

   // output register
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   pixel_out_type rsp_payload_ff;
   pixel_out_type rsp_payload_in;

   // datapath
   logic signed [RAW_W-1:0] raw;
   logic [EXT_W-1:0]        raw_ext;
   logic [EXT_W-1:0]        clamp_ext;
   logic [CLAMP_W-1:0]      clamped;
   logic [Y_W-1:0]          rom_data;
   logic [BYTE_W-1:0]       whole;
   logic [DITHER_FRAC_BITS-1:0] frac;
   logic                    round_up;
   logic [BYTE_W-1:0]       colour_byte;
   logic [ALPHA_W-1:0]      alpha_scaled;
   logic [BYTE_W-1:0]       alpha_byte;

   // ---------------------------------------------------------------------
   // channel select and clamp to [0, one]
   // ---------------------------------------------------------------------
   always_comb begin
      unique case (chan_ff)
         CH_RED:   raw = pix_ff.red_linear;
         CH_GREEN: raw = pix_ff.green_linear;
         CH_BLUE:  raw = pix_ff.blue_linear;
         CH_ALPHA: raw = pix_ff.alpha_linear;
         default:  raw = pix_ff.alpha_linear;
      endcase
   end

   assign raw_ext = {2'b00, raw[RAW_W-2:0]};

   always_comb begin
      priority if (raw[RAW_W-1]) begin
         clamp_ext = '0;
      end else if (raw_ext > (EXT_W'(1) << INPUT_FRAC_BITS)) begin
         clamp_ext = EXT_W'(1) << INPUT_FRAC_BITS;
      end else begin
         clamp_ext = raw_ext;
      end
   end

   assign clamped = CLAMP_W'(clamp_ext);

   // ---------------------------------------------------------------------
   // shared gamma rom and lcg unit
   // ---------------------------------------------------------------------
   gdpp_gamma_rom #(
      .INPUT_FRAC_BITS  (INPUT_FRAC_BITS),
      .DITHER_FRAC_BITS (DITHER_FRAC_BITS)
   ) u_gamma_rom (
      .clock (clock),
      .rd_en (rom_rd_en),
      .addr  (clamped),
      .data  (rom_data)
   );

   assign whole = rom_data[Y_W-1:DITHER_FRAC_BITS];
   assign frac  = rom_data[DITHER_FRAC_BITS-1:0];

   gdpp_dither #(
      .DITHER_FRAC_BITS (DITHER_FRAC_BITS)
   ) u_dither (
      .clock     (clock),
      .reset     (reset),
      .seed_step (seed_step),
      .frac      (frac),
      .round_up  (round_up)
   );

   // round up, saturating at full scale
   always_comb begin
      colour_byte = whole;
      if (dither_enable_ff && round_up && (whole != BYTE_MAX)) begin
         colour_byte = whole + BYTE_W'(1);
      end
   end

   // alpha * 255 as a shift and subtract, never above 255
   assign alpha_scaled = ({ {8{1'b0}}, clamped } << 8) - ALPHA_W'(clamped);
   assign alpha_byte   = BYTE_W'(alpha_scaled >> INPUT_FRAC_BITS);

   // ---------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_FETCH;
               chan_in  = CH_RED;
            end
         end
         ST_FETCH: state_in = ST_STEP;
         ST_STEP:  state_in = ST_ROUND;
         ST_ROUND: begin
            if (chan_ff == CH_BLUE) begin
               state_in = ST_ALPHA;
               chan_in  = CH_ALPHA;
            end else begin
               state_in = ST_FETCH;
               chan_in  = chan_type'(chan_ff + 2'd1);
            end
         end
         ST_ALPHA: state_in = ST_PACK;
         ST_PACK: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready   = 1'b0;
      rom_rd_en   = 1'b0;
      seed_step   = 1'b0;
      colour_load = 1'b0;
      alpha_load  = 1'b0;
      pack_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready   = 1'b1;
         ST_FETCH: rom_rd_en   = 1'b1;
         ST_STEP:  seed_step   = dither_enable_ff;
         ST_ROUND: colour_load = 1'b1;
         ST_ALPHA: alpha_load  = 1'b1;
         ST_PACK:  pack_load   = !rsp_valid_ff || rsp_chan.ready;
         default:  req_ready   = 1'b0;
      endcase
   end

   assign req_chan.ready = req_ready;

   // ---------------------------------------------------------------------
   // pack and output register
   // ---------------------------------------------------------------------
   always_comb begin
      if (byte_order_ff == ORDER_RGBA) begin
         rsp_payload_in.packed_pixel = {red_ff, green_ff, blue_ff, alpha_ff};
      end else begin
         rsp_payload_in.packed_pixel = {alpha_ff, blue_ff, green_ff, red_ff};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (pack_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         chan_ff          <= CH_RED;
         rsp_valid_ff     <= 1'b0;
         dither_enable_ff <= 1'b0;
         byte_order_ff    <= ORDER_ABGR;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DITHER_ENABLE: dither_enable_ff <= csr_wdata;
               CSR_BYTE_ORDER:    byte_order_ff    <= csr_wdata;
               default:           dither_enable_ff <= dither_enable_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_ready) begin
         pix_ff <= req_chan.payload;
      end
      if (colour_load) begin
         unique case (chan_ff)
            CH_RED:   red_ff   <= colour_byte;
            CH_GREEN: green_ff <= colour_byte;
            CH_BLUE:  blue_ff  <= colour_byte;
            CH_ALPHA: alpha_ff <= alpha_byte;
            default:  blue_ff  <= colour_byte;
         endcase
      end
      if (alpha_load) begin
         alpha_ff <= alpha_byte;
      end
      if (pack_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/gdpp_gamma_rom.sv -----
// ----------------------------------------------------------------------------
// gdpp_gamma_rom
// gamma 1/2.2 lookup, contents worked out exactly at elaboration
// ----------------------------------------------------------------------------
`default_nettype none

module gdpp_gamma_rom #(
   parameter int INPUT_FRAC_BITS  = 12,
   parameter int DITHER_FRAC_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [INPUT_FRAC_BITS:0]      addr,
   output logic      [DITHER_FRAC_BITS+7:0]   data
);

   localparam int DEPTH = (1 << INPUT_FRAC_BITS) + 1;
   localparam int Y_W   = DITHER_FRAC_BITS + 8;
   localparam int BIG_W = 320;

   typedef logic [Y_W-1:0]   entry_type;
   typedef logic [BIG_W-1:0] big_type;

   function automatic big_type pow11(input big_type v);
      big_type v2;
      big_type v4;
      big_type v8;
      v2 = v * v;
      v4 = v2 * v2;
      v8 = v4 * v4;
      return v8 * v2 * v;
   endfunction

   // largest y with (y/full)^11 <= (x/one)^5, by binary search on y
   function automatic entry_type gamma_entry(input int unsigned x);
      int unsigned full;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      big_type     xb;
      big_type     x2;
      big_type     rhs;
      full = 32'd255 << DITHER_FRAC_BITS;
      xb   = big_type'(x);
      x2   = xb * xb;
      rhs  = x2 * x2 * xb * pow11(big_type'(full));
      lo   = 0;
      hi   = full;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 1) >> 1);
         if ((pow11(big_type'(mid)) << (5 * INPUT_FRAC_BITS)) <= rhs) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return entry_type'(lo);
   endfunction

   entry_type rom_table [DEPTH];

   for (genvar gx = 0; gx < DEPTH; gx++) begin : g_rom
      localparam entry_type ENTRY = gamma_entry(gx);
      assign rom_table[gx] = ENTRY;
   end

   entry_type data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= rom_table[addr];
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/gdpp_dither.sv -----
// ----------------------------------------------------------------------------
// gdpp_dither
// lcg noise source and round-up compare shared by the colour channels
// ----------------------------------------------------------------------------
`default_nettype none

module gdpp_dither #(
   parameter int DITHER_FRAC_BITS = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        seed_step,
   input  wire logic [DITHER_FRAC_BITS-1:0] frac,
   output logic                             round_up
);
   import gdpp_pkg::*;

   localparam int CMP_W = DITHER_FRAC_BITS + 15;

   logic [31:0] seed_ff;
   logic [31:0] seed_in;
   logic [31:0] seed_prod;

   assign seed_prod = seed_ff * LCG_MUL;

   always_comb begin
      seed_in = seed_ff;
      if (seed_step) begin
         seed_in = seed_prod + LCG_ADD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // seed bits 30..16 as a fraction against the channel fraction
   assign round_up = {seed_ff[30:16], {DITHER_FRAC_BITS{1'b0}}}
                   < CMP_W'({frac, 15'd0});

endmodule

`default_nettype wire
